// ===== rtl/core/srs_pkg.sv =====
// srs_pkg: shared constants, payload types and control structs for the
// stereo linear resampler. No dependencies.
package srs_pkg;

	localparam int SAMPLE_W = 32;
	localparam int PHASE_W  = 39;
	localparam int FRAC_W   = 32;
	localparam int INT_W    = PHASE_W - FRAC_W;
	localparam int WEIGHT_W = 16;
	localparam int STEP_CNT_W = $clog2(WEIGHT_W);
	localparam int RUN_CAP  = 64;
	localparam int RUN_CNT_W = $clog2(RUN_CAP + 1);
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = PHASE_W;

	localparam logic [CFG_IDX_W-1:0] CFG_BYPASS     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = CFG_IDX_W'(1);

	localparam logic [PHASE_W-1:0] ONE_FRAME = PHASE_W'(64'd1 << FRAC_W);
	localparam logic [PHASE_W-1:0] PHASE_MAX = {PHASE_W{1'b1}};
	localparam logic [RUN_CNT_W-1:0] RUN_CAP_CNT = RUN_CNT_W'(RUN_CAP);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] in_left;
		logic signed [SAMPLE_W-1:0] in_right;
	} srs_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_left;
		logic signed [SAMPLE_W-1:0] out_right;
		logic                       last_of_run;
	} srs_out_t;

	typedef struct packed {
		logic                start;
		logic [WEIGHT_W-1:0] weight;
	} srs_mul_ctl_t;

endpackage

// ===== rtl/core/stereo_linear_resampler.sv =====
// Stereo linear resampler: one input item (stereo frame) yields zero to 64 result items.
// In bypass mode an item passes through as one result. Otherwise each result is a 16-step
// bit-serial multiply per channel, both channels in parallel, plus phase check and handoff;
// each input item also goes through accept and phase bookkeeping, and a stalled output
// holds the handoff until the output register is free. One input item is worked on
// at a time; the output register lets the next item be taken while a result still waits.
// Uses srs_pkg and srs_lerp_serial.
module stereo_linear_resampler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  srs_pkg::srs_in_t                  in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output srs_pkg::srs_out_t                 out_data,
	input  logic                              cfg_we,
	input  logic [srs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [srs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import srs_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_MUL   = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t                 state_q;
	logic                   bypass_q;
	logic [PHASE_W-1:0]     step_q;
	logic [PHASE_W-1:0]     phase_q;
	logic                   primed_q;
	logic [RUN_CNT_W-1:0]   cnt_q;
	logic [SAMPLE_W-1:0]    cur_l_q, cur_r_q, prev_l_q, prev_r_q;
	logic                   out_valid_q;
	srs_out_t               out_q;

	logic                   accept;
	logic                   out_free;
	logic                   run_more;
	logic                   int_zero;
	logic [PHASE_W:0]       phase_sum;
	logic [PHASE_W-1:0]     phase_next;
	logic                   last_now;
	srs_mul_ctl_t           mul_ctl;
	logic                   done_l, done_r;
	logic [SAMPLE_W-1:0]    res_l, res_r;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign int_zero  = (phase_q[PHASE_W-1:FRAC_W] == '0);
	assign run_more  = int_zero && (cnt_q != RUN_CAP_CNT);
	assign phase_sum = {1'b0, phase_q} + {1'b0, step_q};
	assign phase_next = phase_sum[PHASE_W] ? PHASE_MAX : phase_sum[PHASE_W-1:0];
	assign last_now  = bypass_q || !int_zero || (cnt_q == RUN_CAP_CNT);

	assign mul_ctl.start  = (state_q == ST_CHECK) && run_more;
	assign mul_ctl.weight = phase_q[FRAC_W-1 -: WEIGHT_W];

	srs_lerp_serial u_lerp_l (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.p0     (prev_l_q),
		.p1     (cur_l_q),
		.done   (done_l),
		.result (res_l)
	);

	srs_lerp_serial u_lerp_r (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.p0     (prev_r_q),
		.p1     (cur_r_q),
		.done   (done_r),
		.result (res_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bypass_q    <= 1'b1;
			step_q      <= ONE_FRAME;
			phase_q     <= '0;
			primed_q    <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BYPASS:     bypass_q <= cfg_wdata[0];
					CFG_PHASE_STEP: step_q   <= cfg_wdata;
					default:        ;
				endcase
			end
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (bypass_q) begin
							state_q <= ST_EMIT;
						end else begin
							primed_q <= 1'b1;
							state_q  <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (run_more) begin
						phase_q <= phase_next;
						cnt_q   <= cnt_q + RUN_CNT_W'(1);
						state_q <= ST_MUL;
					end else begin
						phase_q <= int_zero ? '0 : phase_q - ONE_FRAME;
						state_q <= ST_IDLE;
					end
				end
				ST_MUL: begin
					if (done_l) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= bypass_q ? ST_IDLE : ST_CHECK;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_l_q <= in_data.in_left;
			cur_r_q <= in_data.in_right;
			if (!bypass_q && !primed_q) begin
				prev_l_q <= in_data.in_left;
				prev_r_q <= in_data.in_right;
			end
		end
		if (state_q == ST_CHECK && !run_more) begin
			prev_l_q <= cur_l_q;
			prev_r_q <= cur_r_q;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_q.out_left    <= bypass_q ? cur_l_q : res_l;
			out_q.out_right   <= bypass_q ? cur_r_q : res_r;
			out_q.last_of_run <= last_now;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_run_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= RUN_CAP_CNT)
		else $error("run count beyond cap");

	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		done_l == done_r)
		else $error("channel multipliers out of step");

	a_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		done_l |-> state_q == ST_MUL)
		else $error("multiply finished outside wait state");

	a_load_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT))
		else $error("output loaded outside emit state");

	a_resample_path: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !bypass_q |=> state_q == ST_CHECK && primed_q)
		else $error("accepted item did not enter phase check");

endmodule

// ===== rtl/core/srs_lerp_serial.sv =====
// srs_lerp_serial: one channel of linear interpolation, prev + ((cur - prev) * w >> 16),
// with a bit-serial shift-add multiply over the 16 weight bits. Uses srs_pkg.
module srs_lerp_serial (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  srs_pkg::srs_mul_ctl_t                 ctl,
	input  logic signed [srs_pkg::SAMPLE_W-1:0]   p0,
	input  logic signed [srs_pkg::SAMPLE_W-1:0]   p1,
	output logic                                  done,
	output logic signed [srs_pkg::SAMPLE_W-1:0]   result
);
	import srs_pkg::*;

	logic                       active_q;
	logic                       done_q;
	logic [STEP_CNT_W-1:0]      cnt_q;
	logic [WEIGHT_W-1:0]        w_q;
	logic [SAMPLE_W-1:0]        diff_q;
	logic [SAMPLE_W-1:0]        base_q;
	logic signed [SAMPLE_W:0]   acc_q;
	logic signed [SAMPLE_W:0]   addend;
	logic signed [SAMPLE_W:0]   sum;

	assign addend = w_q[0] ? {diff_q[SAMPLE_W-1], diff_q} : '0;
	assign sum    = acc_q + addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= active_q && !ctl.start && (cnt_q == STEP_CNT_W'(WEIGHT_W - 1));
			if (ctl.start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + STEP_CNT_W'(1);
				if (cnt_q == STEP_CNT_W'(WEIGHT_W - 1)) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	// weight shifts out lsb first, partial sum shifts right each step
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			diff_q <= p1 - p0;
			base_q <= p0;
			w_q    <= ctl.weight;
			acc_q  <= '0;
		end else if (active_q) begin
			w_q   <= w_q >> 1;
			acc_q <= {sum[SAMPLE_W], sum[SAMPLE_W:1]};
		end
	end

	assign done   = done_q;
	assign result = base_q + acc_q[SAMPLE_W-1:0];

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// testbench: self-checking bench for stereo_linear_resampler, with its own
// interpolation predictor, paced input bursts and random output back-pressure.
// Depends on srs_pkg and the stereo_linear_resampler RTL.
module testbench;
	import srs_pkg::*;

	localparam int IDLE_TAIL = 64;
	localparam longint unsigned UNITY = 64'd1 << FRAC_W;
	localparam longint unsigned STEP_LO = 64'd1 << 26;
	localparam longint unsigned STEP_HI = 64'd1 << 38;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	srs_in_t in_data;
	logic out_valid;
	logic out_stall = 1'b0;
	srs_out_t out_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// predictor copy of the block state and registers
	logic m_bypass;
	logic [PHASE_W-1:0] m_step;
	logic [SAMPLE_W-1:0] m_prev_l;
	logic [SAMPLE_W-1:0] m_prev_r;
	logic [PHASE_W-1:0] m_phase;
	logic m_primed;

	srs_out_t due_frames[$];

	int mismatches = 0;
	int frames_sent = 0;
	int results_seen = 0;
	int reg_writes = 0;
	int stall_cycles = 0;
	int stall_pct = 0;
	bit gap_on = 1'b0;
	int burst_left = 0;
	int hold_req = 0;
	int hold_left = 0;

	stereo_linear_resampler u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	function automatic logic [SAMPLE_W-1:0] blend_sample(logic [SAMPLE_W-1:0] a,
			logic [SAMPLE_W-1:0] b, logic [WEIGHT_W-1:0] w);
		logic [SAMPLE_W-1:0] d;
		longint prod;
		d = b - a;
		prod = longint'($signed(d)) * longint'({16'd0, w});
		return a + prod[47:16];
	endfunction

	task automatic reset_model();
		m_bypass = 1'b1;
		m_step = ONE_FRAME;
		m_prev_l = '0;
		m_prev_r = '0;
		m_phase = '0;
		m_primed = 1'b0;
	endtask

	task automatic resample_frame(srs_in_t f);
		logic [SAMPLE_W-1:0] cl;
		logic [SAMPLE_W-1:0] cr;
		logic [PHASE_W:0] acc;
		srs_out_t o;
		int n;
		cl = f.in_left;
		cr = f.in_right;
		if (m_bypass) begin
			o.out_left = cl;
			o.out_right = cr;
			o.last_of_run = 1'b1;
			due_frames.push_back(o);
			return;
		end
		if (!m_primed) begin
			m_prev_l = cl;
			m_prev_r = cr;
			m_primed = 1'b1;
		end
		acc = {1'b0, m_phase};
		n = 0;
		while (n < RUN_CAP && acc[PHASE_W-1:FRAC_W] == '0) begin
			o.out_left = blend_sample(m_prev_l, cl, acc[FRAC_W-1:FRAC_W-WEIGHT_W]);
			o.out_right = blend_sample(m_prev_r, cr, acc[FRAC_W-1:FRAC_W-WEIGHT_W]);
			n++;
			acc = acc + {1'b0, m_step};
			if (acc > {1'b0, PHASE_MAX})
				acc = {1'b0, PHASE_MAX};
			o.last_of_run = (n == RUN_CAP) || (acc[PHASE_W-1:FRAC_W] != '0);
			due_frames.push_back(o);
		end
		m_phase = (acc >= {1'b0, ONE_FRAME}) ? PHASE_W'(acc - {1'b0, ONE_FRAME}) : '0;
		m_prev_l = cl;
		m_prev_r = cr;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_BYPASS)
			m_bypass = value[0];
		else if (idx == CFG_PHASE_STEP)
			m_step = value;
		reg_writes++;
	endtask

	task automatic send_frame(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r);
		srs_in_t f;
		f.in_left = l;
		f.in_right = r;
		if (gap_on) begin
			if (burst_left <= 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 8);
			end
			burst_left--;
		end
		in_valid <= 1'b1;
		in_data <= f;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		frames_sent++;
		resample_frame(f);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_frames.size() != 0)
			@(posedge clk);
		repeat (IDLE_TAIL) @(posedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(1) ? 32'hffff_ffff : 32'h0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_step();
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned r;
		r = {$urandom, $urandom};
		case ($urandom_range(5))
			0, 1: begin
				lo = 64'd1 << 29;
				hi = UNITY;
			end
			2: begin
				lo = UNITY >> 1;
				hi = UNITY << 1;
			end
			3: begin
				lo = UNITY;
				hi = UNITY << 3;
			end
			4: begin
				lo = STEP_LO;
				hi = STEP_LO << $urandom_range(12);
			end
			default: return $urandom_range(1) ? CFG_DATA_W'(STEP_LO) : CFG_DATA_W'(STEP_HI);
		endcase
		return CFG_DATA_W'(lo + r % (hi - lo + 1));
	endfunction

	task automatic report_mismatch(string what, srs_out_t want, srs_out_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected %h %h %b, got %h %h %b", $realtime, what,
				want.out_left, want.out_right, want.last_of_run,
				got.out_left, got.out_right, got.last_of_run);
	endtask

	// receiver: random stall pattern, plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		srs_out_t want;
		if (arst_n && in_valid && in_stall)
			stall_cycles++;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (due_frames.size() == 0) begin
				report_mismatch("unexpected result", '0, out_data);
			end else begin
				want = due_frames.pop_front();
				if (out_data.out_left !== want.out_left ||
						out_data.out_right !== want.out_right ||
						out_data.last_of_run !== want.last_of_run)
					report_mismatch("result mismatch", want, out_data);
			end
		end
	end

	task automatic test_bypass_default();
		send_frame(32'h7fff_ffff, 32'h8000_0000);
		send_frame(32'h8000_0000, 32'h7fff_ffff);
		send_frame(32'h0, 32'hffff_ffff);
		send_frame($urandom, $urandom);
		wait_idle();
	endtask

	task automatic test_first_frame();
		write_reg(CFG_BYPASS, '0);
		write_reg(CFG_PHASE_STEP, ONE_FRAME);
		send_frame(32'h1234_5678, 32'h8765_4321);
		send_frame(32'h7fff_ffff, 32'h8000_0000);
		send_frame(32'h8000_0000, 32'h7fff_ffff);
		wait_idle();
	endtask

	task automatic test_extremes();
		write_reg(CFG_PHASE_STEP, CFG_DATA_W'(UNITY >> 1));
		send_frame(32'h7fff_ffff, 32'h8000_0000);
		send_frame(32'h8000_0000, 32'h7fff_ffff);
		send_frame(32'h7fff_ffff, 32'h0);
		send_frame(32'hffff_ffff, 32'h8000_0000);
		send_frame(32'h0, 32'h7fff_ffff);
		send_frame(32'h8000_0000, 32'hffff_ffff);
		wait_idle();
	endtask

	task automatic test_dense_upsample();
		write_reg(CFG_PHASE_STEP, CFG_DATA_W'(STEP_LO));
		send_frame(32'h8000_0000, 32'h7fff_ffff);
		send_frame(32'h7fff_ffff, 32'h8000_0000);
		send_frame($urandom, $urandom);
		wait_idle();
	endtask

	task automatic test_bypass_holds_state();
		write_reg(CFG_BYPASS, CFG_DATA_W'(1));
		send_frame($urandom, $urandom);
		send_frame(32'h0, 32'h0);
		wait_idle();
		write_reg(CFG_BYPASS, '0);
		send_frame($urandom, $urandom);
		send_frame($urandom, $urandom);
		wait_idle();
	endtask

	task automatic test_random_rates();
		for (int p = 0; p < 8; p++) begin
			stall_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 25 : 60;
			gap_on = (p % 4 != 0);
			write_reg(CFG_BYPASS, CFG_DATA_W'($urandom_range(7) == 0));
			write_reg(CFG_PHASE_STEP, rand_step());
			for (int i = 0; i < 5; i++)
				send_frame(rand_sample(), rand_sample());
			wait_idle();
		end
	endtask

	task automatic test_backpressure();
		gap_on = 1'b0;
		stall_pct = 0;
		write_reg(CFG_BYPASS, '0);
		write_reg(CFG_PHASE_STEP, CFG_DATA_W'(64'd1 << 29));
		hold_req = 1500;
		for (int i = 0; i < 12; i++)
			send_frame(rand_sample(), rand_sample());
		wait_idle();
		stall_pct = 30;
		gap_on = 1'b1;
	endtask

	task automatic test_deep_decimation();
		write_reg(CFG_PHASE_STEP, CFG_DATA_W'(STEP_HI));
		for (int i = 0; i < 66; i++)
			send_frame($urandom, $urandom);
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		reset_model();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_bypass_default();
		test_first_frame();
		test_extremes();
		test_dense_upsample();
		test_bypass_holds_state();
		test_random_rates();
		test_backpressure();
		test_deep_decimation();

		$display("sent %0d frames, checked %0d results, %0d register writes",
			frames_sent, results_seen, reg_writes);
		$display("steps from 1/64 to 64 frames, bypass switching, %0d input stall cycles",
			stall_cycles);
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule
